// File: src/assert_macros.svh
// Assertion macros used by the checker file, fpa_checker.sv.
// Depends on nothing; take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Implication into the next cycle, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: src/fpa_pkg.sv
// Types and constants of the flash page allocator.
// Used by every module of the block; depends on nothing.
package fpa_pkg;

	localparam int unsigned NUM_BLOCKS_DEF      = 1024;
	localparam int unsigned PAGES_PER_BLOCK_DEF = 256;
	localparam int unsigned BLK_W               = 10;
	localparam int unsigned ADDR_W              = 18;
	localparam int unsigned OPA_W               = 11;
	localparam logic [OPA_W-1:0] OPA_RESET      = 11'd32;
	localparam int unsigned CMDQ_DEPTH          = 2;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CK_NOP,
		CK_ADD,
		CK_ALLOC,
		CK_FREE,
		CK_CLEAR
	} cmd_kind_t;

	typedef enum logic {
		BK_EXEC,
		BK_FETCH
	} back_state_t;

	typedef struct packed {
		op_t              op;
		logic [BLK_W-1:0] block_index;
		logic             bad_block;
		logic             pool;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] page_address;
		status_t           status;
	} rsp_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [BLK_W-1:0] block_index;
		logic             pool;
	} cmd_t;

endpackage

// File: src/fpa_front.sv
// Front end: accepts requests and decodes them into commands.
// Depends on fpa_pkg; feeds fpa_cmdq.
module fpa_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  fpa_pkg::req_t req,
	output logic          push_valid,
	output fpa_pkg::cmd_t push_data,
	input  logic          push_ready
);
	import fpa_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_dec;
	logic accept;

	always_comb begin
		cmd_dec.block_index = req.block_index;
		cmd_dec.pool        = req.pool;
		case (req.op)
			OP_ADD:   cmd_dec.kind = req.bad_block ? CK_NOP : CK_ADD;
			OP_ALLOC: cmd_dec.kind = CK_ALLOC;
			OP_FREE:  cmd_dec.kind = CK_FREE;
			OP_CLEAR: cmd_dec.kind = CK_CLEAR;
			default:  cmd_dec.kind = CK_NOP;
		endcase
	end

	assign req_stall  = valid_s1 && !push_ready;
	assign accept     = req_valid && !req_stall;
	assign push_valid = valid_s1;
	assign push_data  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_dec;
		end
	end

endmodule

// File: src/fpa_cmdq.sv
// Short command queue between front end and back end.
// Depends on fpa_pkg.
module fpa_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  fpa_pkg::cmd_t push_data,
	output logic          push_ready,
	output logic          pop_valid,
	output fpa_pkg::cmd_t pop_data,
	input  logic          pop_ready
);
	import fpa_pkg::*;

	localparam int unsigned PTR_W = $clog2(CMDQ_DEPTH);
	localparam int unsigned CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             entry_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(CMDQ_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: src/fpa_back.sv
// Back end: free block pools, write cursors and the response register.
// Depends on fpa_pkg; takes commands from fpa_cmdq.
module fpa_back #(
	parameter int unsigned NUM_BLOCKS      = fpa_pkg::NUM_BLOCKS_DEF,
	parameter int unsigned PAGES_PER_BLOCK = fpa_pkg::PAGES_PER_BLOCK_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pop_valid,
	input  fpa_pkg::cmd_t            pop_data,
	output logic                     pop_ready,
	input  logic                     cfg_we,
	input  logic [fpa_pkg::OPA_W-1:0] cfg_wdata,
	output logic                     rsp_valid,
	output fpa_pkg::rsp_t            rsp,
	input  logic                     rsp_stall
);
	import fpa_pkg::*;

	localparam int unsigned PTR_W = $clog2(NUM_BLOCKS);
	localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int unsigned OFF_W = $clog2(PAGES_PER_BLOCK + 1);

	logic [BLK_W-1:0] mem_n [NUM_BLOCKS];
	logic [BLK_W-1:0] mem_r [NUM_BLOCKS];
	logic [BLK_W-1:0] rdn_q;
	logic [BLK_W-1:0] rdr_q;

	logic [PTR_W-1:0] head_q  [2];
	logic [PTR_W-1:0] tail_q  [2];
	logic [CNT_W-1:0] count_q [2];
	logic [BLK_W-1:0] block_q [2];
	logic [OFF_W-1:0] off_q   [2];
	logic             open_q  [2];
	logic [OPA_W-1:0] built_q;
	logic [OPA_W-1:0] op_area_q;
	logic             pop_pool_q;

	back_state_t state_q;
	back_state_t state_d;

	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             can_emit;
	logic             exec;
	logic             to_res;
	logic             psel;
	logic             full;
	logic             empty;
	logic             need_new;
	logic             do_push;
	logic             do_pop;
	logic             do_step;
	logic             do_clear;
	logic             emit;
	logic             fetch_emit;
	rsp_t             rsp_d;
	logic [BLK_W-1:0] rdata;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(NUM_BLOCKS - 1)) ? '0 : p + 1'b1;
	endfunction

	assign can_emit = !rsp_valid_q || !rsp_stall;
	assign to_res   = built_q < op_area_q;
	assign psel     = (pop_data.kind == CK_ADD) ? to_res : pop_data.pool;
	assign full     = count_q[psel] == CNT_W'(NUM_BLOCKS);
	assign empty    = count_q[psel] == '0;
	assign need_new = !open_q[psel] || (off_q[psel] >= OFF_W'(PAGES_PER_BLOCK));
	assign rdata    = pop_pool_q ? rdr_q : rdn_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_EXEC:  if (do_pop) state_d = BK_FETCH;
			BK_FETCH: if (can_emit) state_d = BK_EXEC;
			default:  state_d = BK_EXEC;
		endcase
	end

	always_comb begin
		exec       = 1'b0;
		do_push    = 1'b0;
		do_pop     = 1'b0;
		do_step    = 1'b0;
		do_clear   = 1'b0;
		emit       = 1'b0;
		fetch_emit = 1'b0;
		rsp_d.page_address = '0;
		rsp_d.status       = ST_OK;
		case (state_q)
			BK_EXEC: begin
				exec = pop_valid && can_emit;
				case (pop_data.kind)
					CK_ADD, CK_FREE: begin
						do_push      = exec && !full;
						rsp_d.status = full ? ST_FULL : ST_OK;
					end
					CK_ALLOC: begin
						do_pop  = exec && need_new && !empty;
						do_step = exec && !need_new;
						if (need_new && empty) begin
							rsp_d.status = ST_EMPTY;
						end else if (!need_new) begin
							rsp_d.page_address = ADDR_W'(block_q[psel]) *
								ADDR_W'(PAGES_PER_BLOCK) + ADDR_W'(off_q[psel]);
						end
					end
					CK_CLEAR: do_clear = exec;
					default: ;
				endcase
				emit = exec && !do_pop;
			end
			BK_FETCH: begin
				fetch_emit         = can_emit;
				emit               = can_emit;
				rsp_d.page_address = ADDR_W'(rdata) * ADDR_W'(PAGES_PER_BLOCK);
			end
			default: ;
		endcase
	end

	assign pop_ready = exec;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_EXEC;
			rsp_valid_q <= 1'b0;
			op_area_q   <= OPA_RESET;
			built_q     <= '0;
			pop_pool_q  <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
				block_q[i] <= '0;
				off_q[i]   <= '0;
				open_q[i]  <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				op_area_q <= cfg_wdata;
			end
			if (do_push) begin
				tail_q[psel]  <= ring_next(tail_q[psel]);
				count_q[psel] <= count_q[psel] + 1'b1;
				if (pop_data.kind == CK_ADD && to_res) begin
					built_q <= built_q + 1'b1;
				end
			end
			if (do_pop) begin
				head_q[psel]  <= ring_next(head_q[psel]);
				count_q[psel] <= count_q[psel] - 1'b1;
				open_q[psel]  <= 1'b1;
				off_q[psel]   <= OFF_W'(1);
				pop_pool_q    <= psel;
			end
			if (do_step) begin
				off_q[psel] <= off_q[psel] + 1'b1;
			end
			if (do_clear) begin
				built_q <= '0;
				for (int i = 0; i < 2; i++) begin
					head_q[i]  <= '0;
					tail_q[i]  <= '0;
					count_q[i] <= '0;
				end
			end
			if (fetch_emit) begin
				block_q[pop_pool_q] <= rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push && !psel) begin
			mem_n[tail_q[0]] <= pop_data.block_index;
		end
		if (do_pop && !psel) begin
			rdn_q <= mem_n[head_q[0]];
		end
	end

	always_ff @(posedge clk) begin
		if (do_push && psel) begin
			mem_r[tail_q[1]] <= pop_data.block_index;
		end
		if (do_pop && psel) begin
			rdr_q <= mem_r[head_q[1]];
		end
	end

endmodule

// File: src/flash_page_allocator.sv
// Flash page allocator top level: front end, command queue and back end.
// Depends on fpa_pkg, fpa_front, fpa_cmdq and fpa_back.
//
// Requests (add block, allocate page, free block, clear pools) enter a decode
// register, wait in a two-entry command queue and are executed by the back
// end, which keeps a normal and a reserved FIFO of free block numbers in
// on-chip memory plus one write cursor per pool. Every request gives exactly
// one response, in order, held in a response register until taken. The back
// end executes one request per cycle while the response register is free; an
// allocate that opens a fresh block adds a fetch state, as the block number
// comes from pool memory through its registered read port. Pool memories need
// no initialization after reset. op_area_blocks (reset 32) is written through
// cfg_we/cfg_wdata and must only change while no request is in flight.
module flash_page_allocator #(
	parameter int unsigned NUM_BLOCKS      = fpa_pkg::NUM_BLOCKS_DEF,
	parameter int unsigned PAGES_PER_BLOCK = fpa_pkg::PAGES_PER_BLOCK_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  fpa_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output fpa_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [fpa_pkg::OPA_W-1:0] cfg_wdata
);
	import fpa_pkg::*;

	logic push_valid;
	cmd_t push_data;
	logic push_ready;
	logic pop_valid;
	cmd_t pop_data;
	logic pop_ready;

	fpa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	fpa_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	fpa_back #(
		.NUM_BLOCKS      (NUM_BLOCKS),
		.PAGES_PER_BLOCK (PAGES_PER_BLOCK)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_stall (rsp_stall)
	);

endmodule

// File: src/fpa_checker.sv
// Port-level checks of the flash page allocator, bound to the top level.
// Depends on fpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input fpa_pkg::rsp_t rsp
);
	import fpa_pkg::*;

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
	`ASSERT_IMPLY(a_status_code, clk, arst_n, rsp_valid, rsp.status == ST_OK || rsp.status == ST_EMPTY || rsp.status == ST_FULL)
	`ASSERT_IMPLY(a_err_no_addr, clk, arst_n, rsp_valid && rsp.status != ST_OK, rsp.page_address == '0)

endmodule

bind flash_page_allocator fpa_checker u_fpa_checker (.*);

// File: sim/tb.sv
// Testbench for flash_page_allocator: directed and random requests over the
// valid/stall ports, each response checked in order against a pool tracker.
// Depends on fpa_pkg and the flash_page_allocator RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fpa_pkg::*;

	localparam int unsigned DEPTH         = NUM_BLOCKS_DEF;
	localparam int unsigned PAGES         = PAGES_PER_BLOCK_DEF;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned REPORT_MAX    = 10;
	localparam bit          NORMAL        = 1'b0;
	localparam bit          RESERVED      = 1'b1;

	class pool_tracker;
		logic [BLK_W-1:0] ring [2][DEPTH];
		int unsigned      head [2];
		int unsigned      tail [2];
		int unsigned      count [2];
		int unsigned      cur_block [2];
		int unsigned      offset [2];
		bit               is_open [2];
		int unsigned      reserved_built;
		int unsigned      op_area;
		rsp_t             due_responses [$];
		int unsigned      mismatches;

		function new();
			for (int p = 0; p < 2; p++) begin
				head[p] = 0;
				tail[p] = 0;
				count[p] = 0;
				cur_block[p] = 0;
				offset[p] = 0;
				is_open[p] = 1'b0;
			end
			reserved_built = 0;
			op_area = 32'(OPA_RESET);
			mismatches = 0;
		endfunction

		function status_t pool_push(bit p, logic [BLK_W-1:0] blk);
			if (count[p] >= DEPTH)
				return ST_FULL;
			ring[p][tail[p]] = blk;
			tail[p] = (tail[p] + 1) % DEPTH;
			count[p]++;
			return ST_OK;
		endfunction

		function status_t next_page(bit p, output logic [ADDR_W-1:0] addr);
			addr = '0;
			if (!is_open[p] || offset[p] >= PAGES) begin
				if (count[p] == 0)
					return ST_EMPTY;
				cur_block[p] = 32'(ring[p][head[p]]);
				head[p] = (head[p] + 1) % DEPTH;
				count[p]--;
				is_open[p] = 1'b1;
				offset[p] = 1;
				addr = ADDR_W'(cur_block[p] * PAGES);
				return ST_OK;
			end
			addr = ADDR_W'(cur_block[p] * PAGES + offset[p]);
			offset[p]++;
			return ST_OK;
		endfunction

		function void take_request(req_t r);
			rsp_t              want;
			logic [ADDR_W-1:0] addr;
			want.page_address = '0;
			want.status = ST_OK;
			case (r.op)
				OP_ADD: if (!r.bad_block) begin
					if (reserved_built < op_area) begin
						want.status = pool_push(RESERVED, r.block_index);
						if (want.status == ST_OK)
							reserved_built++;
					end else begin
						want.status = pool_push(NORMAL, r.block_index);
					end
				end
				OP_ALLOC: begin
					want.status = next_page(r.pool, addr);
					want.page_address = addr;
				end
				OP_FREE: want.status = pool_push(r.pool, r.block_index);
				OP_CLEAR: begin
					for (int p = 0; p < 2; p++) begin
						head[p] = 0;
						tail[p] = 0;
						count[p] = 0;
					end
					reserved_built = 0;
				end
				default: ;
			endcase
			due_responses.push_back(want);
		endfunction

		function void match_response(rsp_t got);
			rsp_t want;
			if (due_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected response: page_address %0d status %0d",
						got.page_address, got.status);
				return;
			end
			want = due_responses.pop_front();
			if (got.page_address !== want.page_address || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display({"response mismatch: expected page_address %0d status %0d,",
						" got page_address %0d status %0d"},
						want.page_address, want.status, got.page_address, got.status);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;
	logic             cfg_we;
	logic [OPA_W-1:0] cfg_wdata;

	pool_tracker tracker;
	int unsigned idle_pct;
	int unsigned cycle_count = 0;

	flash_page_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			rsp_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.match_response(rsp);

	task automatic send_request(input op_t op, input logic [BLK_W-1:0] blk,
		input logic bad, input logic pl);
		req_t r;
		r.op = op;
		r.block_index = blk;
		r.bad_block = bad;
		r.pool = pl;
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		tracker.take_request(r);
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (tracker.due_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_op_area(input logic [OPA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		tracker.op_area = 32'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_mixed(input bit lean);
		int unsigned pick;
		logic        pl;
		pick = $urandom_range(99);
		pl = ($urandom_range(99) < 85) ? lean : !lean;
		if (pick < 50)
			send_request(OP_ALLOC, BLK_W'($urandom), 1'($urandom), pl);
		else if (pick < 70)
			send_request(OP_FREE, BLK_W'($urandom), 1'($urandom), pl);
		else if (pick < 97)
			send_request(OP_ADD, BLK_W'($urandom), $urandom_range(9) == 0, 1'($urandom));
		else
			send_request(OP_CLEAR, BLK_W'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic run_phase(input logic [OPA_W-1:0] area, input int unsigned n);
		bit          lean;
		int unsigned burst;
		settle();
		write_op_area(area);
		lean = 1'($urandom_range(1));
		burst = $urandom_range(5, 30);
		send_request(OP_CLEAR, BLK_W'($urandom), 1'($urandom), 1'($urandom));
		for (int unsigned i = 0; i < burst; i++)
			send_request(OP_ADD, BLK_W'($urandom), $urandom_range(9) == 0, 1'($urandom));
		for (int unsigned i = burst; i < n; i++)
			send_mixed(lean);
	endtask

	task automatic fill_reserved();
		settle();
		write_op_area(11'd1024);
		send_request(OP_CLEAR, BLK_W'($urandom), 1'($urandom), 1'($urandom));
		idle_pct = 0;
		while (tracker.count[RESERVED] < DEPTH) begin
			if (tracker.count[RESERVED] > 600)
				idle_pct = 8;
			if ($urandom_range(3) == 0)
				send_request(OP_FREE, BLK_W'($urandom), 1'($urandom), RESERVED);
			else
				send_request(OP_ADD, BLK_W'($urandom), $urandom_range(19) == 0,
					1'($urandom));
		end
		send_request(OP_ADD, BLK_W'($urandom), 1'b0, 1'($urandom));
		send_request(OP_FREE, BLK_W'($urandom), 1'($urandom), RESERVED);
		send_request(OP_ADD, BLK_W'($urandom), 1'b1, 1'($urandom));
		for (int unsigned i = 0; i < 250; i++)
			if ($urandom_range(99) < 85)
				send_request(OP_ALLOC, BLK_W'($urandom), 1'($urandom), RESERVED);
			else
				send_mixed(RESERVED);
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_pct = 8;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(OP_ALLOC, 10'd0, 1'b0, NORMAL);
		send_request(OP_ALLOC, 10'h3FF, 1'b1, RESERVED);
		send_request(OP_ADD, 10'h3FF, 1'b1, NORMAL);
		send_request(OP_ADD, 10'd0, 1'b0, NORMAL);
		send_request(OP_ADD, 10'h3FF, 1'b0, RESERVED);
		send_request(OP_ALLOC, 10'h155, 1'b0, RESERVED);
		send_request(OP_ALLOC, 10'h2AA, 1'b1, RESERVED);
		send_request(OP_FREE, 10'h3FF, 1'b0, NORMAL);
		send_request(OP_FREE, 10'h2AA, 1'b1, NORMAL);
		send_request(OP_ALLOC, 10'd0, 1'b0, NORMAL);
		send_request(OP_ALLOC, 10'd0, 1'b0, NORMAL);
		send_request(OP_FREE, 10'h155, 1'b0, RESERVED);
		send_request(OP_CLEAR, 10'h3FF, 1'b1, RESERVED);
		// open cursors survive a clear
		send_request(OP_ALLOC, 10'd0, 1'b0, NORMAL);
		send_request(OP_ALLOC, 10'd0, 1'b0, RESERVED);
		send_request(OP_ADD, 10'h2AA, 1'b0, NORMAL);
		send_request(OP_ALLOC, 10'd0, 1'b0, RESERVED);
		send_request(OP_CLEAR, 10'd0, 1'b0, NORMAL);
		send_request(OP_ALLOC, 10'd0, 1'b0, NORMAL);

		run_phase(11'd0, 40);
		run_phase(11'd1024, 40);
		fill_reserved();
		run_phase(11'd3, 40);
		run_phase(OPA_W'($urandom_range(1024)), 40);
		run_phase(11'd32, 30);
		settle();

		if (tracker.mismatches == 0 && tracker.due_responses.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
